[sv/oladl_pkg.sv]
// shared types and constants for the ordered list block
`timescale 1ns / 1ps

package oladl_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int WORD_W         = 32;
    localparam int OPCODE_W       = 2;
    localparam int STATUS_W       = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_DISPLAY = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_NONE  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_APPEND,
        CMD_SHIFT,
        CMD_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                cmd;
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] head;
    } cell_ctrl_t;

endpackage

[sv/oladl_cell.sv]
// one list cell: holds one entry, compares it with the key and shifts with its neighbour
`timescale 1ns / 1ps

module oladl_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 6
) (
    input  logic                                  clk,
    input  oladl_pkg::cell_ctrl_t                 ctrl,
    input  logic [CNT_W-1:0]                      count,
    input  logic signed [oladl_pkg::WORD_W-1:0]   neighbour_value,
    input  logic                                  found_in,
    output logic                                  found_out,
    output logic                                  hit,
    output logic signed [oladl_pkg::WORD_W-1:0]   value
);

    localparam logic [CNT_W-1:0] IDX    = CNT_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(CELL_INDEX + 1);

    logic signed [oladl_pkg::WORD_W-1:0] value_reg;
    logic signed [oladl_pkg::WORD_W-1:0] value_next;
    logic                                occupied;

    assign occupied  = IDX < count;
    assign found_out = found_in | (occupied && (value_reg == ctrl.key));
    assign hit       = found_in & occupied;
    assign value     = value_reg;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.cmd)
            oladl_pkg::CMD_APPEND:
            begin
                if (IDX == count)
                begin
                    value_next = ctrl.key;
                end
            end
            oladl_pkg::CMD_SHIFT:
            begin
                if (found_in)
                begin
                    value_next = neighbour_value;
                end
            end
            oladl_pkg::CMD_ROTATE:
            begin
                value_next = (IDX_P1 == count) ? ctrl.head : neighbour_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

[sv/ordered_list_append_delete_after_top.sv]
// top level of the ordered list: cell chain, count, display sequencer and output register
`timescale 1ns / 1ps

// Bounded list of LIST_DEPTH signed 32-bit words in insertion order, held in a chain
// of cells. Append, delete-after and the unused opcode are each done in the accepting
// cycle: every cell compares its entry with the key at once, a found flag ripples down
// the chain and the cells behind the removed entry each take their neighbour's word in
// the same edge. Display on an empty list is done in the accepting cycle too; otherwise
// the accepting cycle starts the run, then the chain rotates one place per cycle while
// the output register is free and cell 0 feeds the output, so the input is held off
// until the last entry has left. Each item's results go through a single output
// register; a new item is taken only when that register is empty or empties in the
// same edge, so a result that waits under out_stall holds off the input. No clearing
// pass after reset; entries are tracked by the count alone.
module ordered_list_append_delete_after_top #(
    parameter int LIST_DEPTH = oladl_pkg::LIST_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [oladl_pkg::OPCODE_W-1:0]      opcode,
    input  logic signed [oladl_pkg::WORD_W-1:0] operand_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [oladl_pkg::WORD_W-1:0] entry_value,
    output logic [oladl_pkg::STATUS_W-1:0]      status,
    output logic                                last_of_run
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_DISP
    } state_t;

    state_t                              state_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    remain_reg;
    logic                                out_valid_reg;
    logic signed [oladl_pkg::WORD_W-1:0] entry_value_reg;
    logic [oladl_pkg::STATUS_W-1:0]      status_reg;
    logic                                last_reg;

    logic                                out_free;
    logic                                accept;
    logic                                full;
    logic                                do_delete;
    oladl_pkg::cell_ctrl_t               ctrl;

    logic signed [oladl_pkg::WORD_W-1:0] cell_value [LIST_DEPTH];
    logic [LIST_DEPTH:0]                 found_chain;
    logic [LIST_DEPTH-1:0]               hit_vec;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign accept    = in_valid && !in_stall;
    assign full      = count_reg >= FULL_COUNT;
    assign do_delete = |hit_vec;

    assign out_valid   = out_valid_reg;
    assign entry_value = entry_value_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

    assign found_chain[0] = 1'b0;

    always_comb
    begin
        ctrl.cmd  = oladl_pkg::CMD_HOLD;
        ctrl.key  = operand_value;
        ctrl.head = cell_value[0];
        if (state_reg == ST_DISP)
        begin
            if (out_free)
            begin
                ctrl.cmd = oladl_pkg::CMD_ROTATE;
            end
        end
        else if (accept)
        begin
            if ((opcode == oladl_pkg::OP_APPEND) && !full)
            begin
                ctrl.cmd = oladl_pkg::CMD_APPEND;
            end
            else if ((opcode == oladl_pkg::OP_DELETE) && do_delete)
            begin
                ctrl.cmd = oladl_pkg::CMD_SHIFT;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            logic signed [oladl_pkg::WORD_W-1:0] nb;
            if (g == LIST_DEPTH - 1)
            begin : g_end
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = cell_value[g+1];
            end
            oladl_cell #(
                .CELL_INDEX (g),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk             (clk),
                .ctrl            (ctrl),
                .count           (count_reg),
                .neighbour_value (nb),
                .found_in        (found_chain[g]),
                .found_out       (found_chain[g+1]),
                .hit             (hit_vec[g]),
                .value           (cell_value[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            remain_reg      <= '0;
            out_valid_reg   <= 1'b0;
            entry_value_reg <= '0;
            status_reg      <= oladl_pkg::STATUS_OK;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (opcode)
                            oladl_pkg::OP_APPEND:
                            begin
                                out_valid_reg   <= 1'b1;
                                entry_value_reg <= '0;
                                last_reg        <= 1'b1;
                                if (full)
                                begin
                                    status_reg <= oladl_pkg::STATUS_FULL;
                                end
                                else
                                begin
                                    status_reg <= oladl_pkg::STATUS_OK;
                                    count_reg  <= count_reg + ONE;
                                end
                            end
                            oladl_pkg::OP_DELETE:
                            begin
                                out_valid_reg   <= 1'b1;
                                entry_value_reg <= '0;
                                last_reg        <= 1'b1;
                                if (do_delete)
                                begin
                                    status_reg <= oladl_pkg::STATUS_OK;
                                    count_reg  <= count_reg - ONE;
                                end
                                else
                                begin
                                    status_reg <= oladl_pkg::STATUS_NONE;
                                end
                            end
                            oladl_pkg::OP_DISPLAY:
                            begin
                                if (count_reg == '0)
                                begin
                                    out_valid_reg   <= 1'b1;
                                    entry_value_reg <= '0;
                                    status_reg      <= oladl_pkg::STATUS_EMPTY;
                                    last_reg        <= 1'b1;
                                end
                                else
                                begin
                                    state_reg  <= ST_DISP;
                                    remain_reg <= count_reg;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_DISP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        entry_value_reg <= cell_value[0];
                        status_reg      <= oladl_pkg::STATUS_OK;
                        last_reg        <= remain_reg == ONE;
                        remain_reg      <= remain_reg - ONE;
                        if (remain_reg == ONE)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count beyond list depth");

    a_disp_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISP) |-> ((remain_reg != '0) && (remain_reg <= count_reg)))
        else $error("display counter out of range");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == oladl_pkg::OP_APPEND) && full) |=> $stable(count_reg))
        else $error("count changed on dropped append");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == oladl_pkg::OP_DELETE) && do_delete)
        |=> (count_reg == $past(count_reg) - ONE))
        else $error("delete did not drop count by one");

    a_disp_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DISP) && out_free && (remain_reg == ONE))
        |=> (out_valid_reg && last_reg && (state_reg == ST_IDLE)))
        else $error("display run not closed on last entry");

endmodule
